[hdl/fqp_pkg.sv]
`timescale 1ns / 1ps

package fqp_pkg;

  // parse phases
  localparam logic [3:0] PH_DELIM  = 4'd0;
  localparam logic [3:0] PH_HEADER = 4'd1;
  localparam logic [3:0] PH_SEQ    = 4'd2;
  localparam logic [3:0] PH_PLUS   = 4'd3;
  localparam logic [3:0] PH_SKIP   = 4'd4;
  localparam logic [3:0] PH_QUAL   = 4'd5;
  localparam logic [3:0] PH_FSEQ   = 4'd6;

  // detected or forced format
  localparam logic [1:0] FMT_NONE    = 2'd0;
  localparam logic [1:0] FMT_FASTQ   = 2'd1;
  localparam logic [1:0] FMT_FASTA   = 2'd2;
  localparam logic [1:0] FMT_UNKNOWN = 2'd3;

  // format_mode register values
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_FASTQ = 2'd1;
  localparam logic [1:0] MODE_FASTA = 2'd2;

  // byte classes
  localparam logic [1:0] CLS_DELIM  = 2'd0;
  localparam logic [1:0] CLS_HEADER = 2'd1;
  localparam logic [1:0] CLS_SEQ    = 2'd2;
  localparam logic [1:0] CLS_QUAL   = 2'd3;

  // result status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_DONE       = 4'd1;
  localparam logic [3:0] ST_END        = 4'd2;
  localparam logic [3:0] ST_BAD_DELIM  = 4'd3;
  localparam logic [3:0] ST_SHORT_HDR  = 4'd4;
  localparam logic [3:0] ST_SHORT_SEQ  = 4'd5;
  localparam logic [3:0] ST_BAD_PLUS   = 4'd6;
  localparam logic [3:0] ST_SHORT_QUAL = 4'd7;
  localparam logic [3:0] ST_MISMATCH   = 4'd8;

  // special bytes
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  // register map
  localparam int unsigned CfgAddrBits = 3;
  localparam logic [0:0]  REG_FORMAT_MODE = 1'b0;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_class;
    logic        record_done;
    logic [3:0]  status;
    logic [15:0] sequence_length;
    logic [31:0] records_seen;
  } result_t;

endpackage

[hdl/fqp_if.sv]
`timescale 1ns / 1ps

interface fqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface fqp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_class;
  logic        record_done;
  logic [3:0]  status;
  logic [15:0] sequence_length;
  logic [31:0] records_seen;

  modport source (output valid, output out_byte, output byte_class, output record_done,
                  output status, output sequence_length, output records_seen,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_class, input record_done,
                  input status, input sequence_length, input records_seen,
                  output ready);
endinterface

[hdl/fqp_cfg.sv]
`timescale 1ns / 1ps

module fqp_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fqp_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output logic [1:0]                         format_mode_o
);

  logic [1:0] mode_q, mode_d;
  logic       sel_mode;

  assign sel_mode = (paddr[fqp_pkg::CfgAddrBits-1] == fqp_pkg::REG_FORMAT_MODE);

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && sel_mode) begin
      mode_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fqp_pkg::MODE_AUTO;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata        = sel_mode ? {30'd0, mode_q} : 32'd0;
  assign pready        = 1'b1;
  assign format_mode_o = mode_q;

endmodule

[hdl/fqp_core.sv]
`timescale 1ns / 1ps

module fqp_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       format_mode_i,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_input_i,
  output fqp_pkg::result_t result_o
);

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  logic [3:0]             phase_q, phase_d;
  logic [1:0]             active_q, active_d;
  logic [LENGTH_BITS-1:0] seq_q, seq_d;
  logic [LENGTH_BITS-1:0] qual_q, qual_d;
  logic                   line_start_q, line_start_d;
  logic [31:0]            recs_q, recs_d;

  logic [7:0]       b;
  logic             eoi;
  logic             forced;
  logic [1:0]       eff_fmt;
  logic [1:0]       delim_fmt;
  logic [1:0]       cls;
  logic [3:0]       status;
  logic             done;
  logic [LENGTH_BITS-1:0] seq_inc, qual_inc;

  assign eoi     = end_of_input_i;
  assign b       = eoi ? 8'd0 : data_byte_i;
  assign forced  = (format_mode_i == fqp_pkg::MODE_FASTQ) ||
                   (format_mode_i == fqp_pkg::MODE_FASTA);
  assign eff_fmt = (format_mode_i == fqp_pkg::MODE_FASTQ) ? fqp_pkg::FMT_FASTQ :
                   (format_mode_i == fqp_pkg::MODE_FASTA) ? fqp_pkg::FMT_FASTA : active_q;
  assign seq_inc  = (seq_q == LenMax) ? seq_q : seq_q + LENGTH_BITS'(1);
  assign qual_inc = (qual_q == LenMax) ? qual_q : qual_q + LENGTH_BITS'(1);

  always_comb begin
    phase_d      = phase_q;
    active_d     = active_q;
    seq_d        = seq_q;
    qual_d       = qual_q;
    line_start_d = line_start_q;
    recs_d       = recs_q;
    cls          = fqp_pkg::CLS_DELIM;
    status       = fqp_pkg::ST_OK;
    done         = 1'b0;
    delim_fmt    = eff_fmt;

    unique case (phase_q)
      fqp_pkg::PH_HEADER: begin
        if (eoi) begin
          if (line_start_q) status = fqp_pkg::ST_SHORT_HDR;
          else if (eff_fmt == fqp_pkg::FMT_FASTA) done = 1'b1;
          else status = fqp_pkg::ST_SHORT_SEQ;
          phase_d = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          phase_d = (eff_fmt == fqp_pkg::FMT_FASTA) ? fqp_pkg::PH_FSEQ : fqp_pkg::PH_SEQ;
          line_start_d = 1'b1;
        end else begin
          cls = fqp_pkg::CLS_HEADER;
          line_start_d = 1'b0;
        end
      end
      fqp_pkg::PH_SEQ: begin
        if (eoi) begin
          status  = line_start_q ? fqp_pkg::ST_SHORT_SEQ : fqp_pkg::ST_BAD_PLUS;
          phase_d = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          phase_d = fqp_pkg::PH_PLUS;
        end else begin
          cls = fqp_pkg::CLS_SEQ;
          line_start_d = 1'b0;
          seq_d = seq_inc;
        end
      end
      fqp_pkg::PH_PLUS: begin
        if (!eoi && b == fqp_pkg::CH_PLUS) begin
          phase_d = fqp_pkg::PH_SKIP;
        end else begin
          status  = fqp_pkg::ST_BAD_PLUS;
          phase_d = fqp_pkg::PH_DELIM;
        end
      end
      fqp_pkg::PH_SKIP: begin
        if (eoi) begin
          status  = fqp_pkg::ST_BAD_PLUS;
          phase_d = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          phase_d = fqp_pkg::PH_QUAL;
          line_start_d = 1'b1;
          qual_d = '0;
        end
      end
      fqp_pkg::PH_QUAL: begin
        if (eoi && line_start_q) begin
          status  = fqp_pkg::ST_SHORT_QUAL;
          phase_d = fqp_pkg::PH_DELIM;
        end else if (eoi || b == fqp_pkg::CH_NL) begin
          if (qual_q == seq_q) done = 1'b1;
          else status = fqp_pkg::ST_MISMATCH;
          phase_d = fqp_pkg::PH_DELIM;
        end else begin
          cls = fqp_pkg::CLS_QUAL;
          line_start_d = 1'b0;
          qual_d = qual_inc;
        end
      end
      fqp_pkg::PH_FSEQ: begin
        if (eoi) begin
          done    = 1'b1;
          phase_d = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          line_start_d = 1'b1;
        end else if (line_start_q && b == fqp_pkg::CH_GT) begin
          done    = 1'b1;
          phase_d = fqp_pkg::PH_HEADER;
        end else begin
          cls = fqp_pkg::CLS_SEQ;
          line_start_d = 1'b0;
          seq_d = seq_inc;
        end
      end
      default: begin
        // delimiter phase, also recovers from unused phase codes
        phase_d = fqp_pkg::PH_DELIM;
        if (eoi) begin
          status = fqp_pkg::ST_END;
        end else begin
          if (!forced && active_q == fqp_pkg::FMT_NONE) begin
            if (b == fqp_pkg::CH_AT) active_d = fqp_pkg::FMT_FASTQ;
            else if (b == fqp_pkg::CH_GT) active_d = fqp_pkg::FMT_FASTA;
            else active_d = fqp_pkg::FMT_UNKNOWN;
            delim_fmt = active_d;
          end
          if ((delim_fmt == fqp_pkg::FMT_FASTQ && b == fqp_pkg::CH_AT) ||
              (delim_fmt == fqp_pkg::FMT_FASTA && b == fqp_pkg::CH_GT)) begin
            phase_d = fqp_pkg::PH_HEADER;
            line_start_d = 1'b1;
            seq_d = '0;
          end else begin
            status = fqp_pkg::ST_BAD_DELIM;
          end
        end
      end
    endcase

    result_o.sequence_length = 16'd0;
    if (done) begin
      status = fqp_pkg::ST_DONE;
      recs_d = recs_q + 32'd1;
      result_o.sequence_length = 16'(seq_q);
      // a '>' that closes a FASTA record opens the next one
      if (phase_d == fqp_pkg::PH_HEADER) begin
        line_start_d = 1'b1;
        seq_d = '0;
      end
    end

    result_o.out_byte     = b;
    result_o.byte_class   = cls;
    result_o.record_done  = done;
    result_o.status       = status;
    result_o.records_seen = recs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= fqp_pkg::PH_DELIM;
      active_q     <= fqp_pkg::FMT_NONE;
      seq_q        <= '0;
      qual_q       <= '0;
      line_start_q <= 1'b1;
      recs_q       <= 32'd0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      active_q     <= active_d;
      seq_q        <= seq_d;
      qual_q       <= qual_d;
      line_start_q <= line_start_d;
      recs_q       <= recs_d;
    end
  end

endmodule

[hdl/fqp_out_reg.sv]
`timescale 1ns / 1ps

module fqp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fqp_pkg::result_t result_i,
  output logic             free_o,
  fqp_out_if.source        out_ch
);

  logic             valid_q, valid_d;
  fqp_pkg::result_t data_q;

  // slot frees up in the same cycle the held transaction is taken
  assign free_o = !valid_q || out_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (out_ch.ready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= result_i;
  end

  assign out_ch.valid           = valid_q;
  assign out_ch.out_byte        = data_q.out_byte;
  assign out_ch.byte_class      = data_q.byte_class;
  assign out_ch.record_done     = data_q.record_done;
  assign out_ch.status          = data_q.status;
  assign out_ch.sequence_length = data_q.sequence_length;
  assign out_ch.records_seen    = data_q.records_seen;

endmodule

[hdl/fastq_fasta_record_parser.sv]
`timescale 1ns / 1ps

// channel   dir  handshake           payload
// in_ch     in   valid / ready       data_byte, end_of_input
// out_ch    out  valid / ready       out_byte, byte_class, record_done, status,
//                                    sequence_length, records_seen
// apb       in   psel/penable/pwrite format_mode at byte address 0
//
// one byte per cycle while the output is not stalled: the phase update and length
// compare sit between the parse state and the result register, so a transaction
// is accepted in each such cycle and its result shows on out_ch in the next cycle
// in_ch.ready drops only while the result register is full and out_ch is stalled
// reset clears the parse state, record count and format_mode; no warm-up

module fastq_fasta_record_parser #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fqp_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  fqp_in_if.sink                          in_ch,
  fqp_out_if.source                       out_ch
);

  logic             accept;
  logic             out_free;
  logic [1:0]       format_mode;
  fqp_pkg::result_t result;

  assign in_ch.ready = out_free;
  assign accept      = in_ch.valid && out_free;

  fqp_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .format_mode_o (format_mode)
  );

  fqp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .format_mode_i  (format_mode),
    .accept_i       (accept),
    .data_byte_i    (in_ch.data_byte),
    .end_of_input_i (in_ch.end_of_input),
    .result_o       (result)
  );

  fqp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (out_free),
    .out_ch   (out_ch)
  );

endmodule

[tb/fqp_parse_checker.sv]
`timescale 1ns / 1ps

module fqp_parse_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [fqp_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                     pwdata,
  fqp_in_if                               in_ch,
  fqp_out_if                              out_ch,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam logic [fqp_pkg::CfgAddrBits-1:0] FormatModeAddr =
    {fqp_pkg::REG_FORMAT_MODE, 2'b00};

  // shadow of the parser state
  logic [1:0]  mode_q;
  logic [1:0]  fmt_q;
  logic [3:0]  phase_q;
  logic [15:0] seq_len_q;
  logic [15:0] qual_len_q;
  logic        line_start_q;
  logic [31:0] rec_cnt_q;

  fqp_pkg::result_t expected_results[$];

  function automatic logic [1:0] effective_fmt();
    if (mode_q == fqp_pkg::MODE_FASTQ) return fqp_pkg::FMT_FASTQ;
    if (mode_q == fqp_pkg::MODE_FASTA) return fqp_pkg::FMT_FASTA;
    return fmt_q;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  task automatic parse_byte(input logic [7:0] din, input logic eoi,
                            output fqp_pkg::result_t r);
    logic [7:0] b;
    logic [1:0] cls;
    logic [3:0] st;
    logic       done;
    b    = eoi ? 8'h00 : din;
    cls  = fqp_pkg::CLS_DELIM;
    st   = fqp_pkg::ST_OK;
    done = 1'b0;
    case (phase_q)
      fqp_pkg::PH_HEADER: begin
        if (eoi) begin
          if (line_start_q) st = fqp_pkg::ST_SHORT_HDR;
          else if (effective_fmt() == fqp_pkg::FMT_FASTA) done = 1'b1;
          else st = fqp_pkg::ST_SHORT_SEQ;
          phase_q = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          phase_q      = (effective_fmt() == fqp_pkg::FMT_FASTA) ? fqp_pkg::PH_FSEQ :
                                                                  fqp_pkg::PH_SEQ;
          line_start_q = 1'b1;
        end else begin
          cls          = fqp_pkg::CLS_HEADER;
          line_start_q = 1'b0;
        end
      end
      fqp_pkg::PH_SEQ: begin
        if (eoi) begin
          st      = line_start_q ? fqp_pkg::ST_SHORT_SEQ : fqp_pkg::ST_BAD_PLUS;
          phase_q = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          phase_q = fqp_pkg::PH_PLUS;
        end else begin
          cls          = fqp_pkg::CLS_SEQ;
          line_start_q = 1'b0;
          seq_len_q    = sat_inc(seq_len_q);
        end
      end
      fqp_pkg::PH_PLUS: begin
        if (!eoi && b == fqp_pkg::CH_PLUS) begin
          phase_q = fqp_pkg::PH_SKIP;
        end else begin
          st      = fqp_pkg::ST_BAD_PLUS;
          phase_q = fqp_pkg::PH_DELIM;
        end
      end
      fqp_pkg::PH_SKIP: begin
        if (eoi) begin
          st      = fqp_pkg::ST_BAD_PLUS;
          phase_q = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          phase_q      = fqp_pkg::PH_QUAL;
          line_start_q = 1'b1;
          qual_len_q   = '0;
        end
      end
      fqp_pkg::PH_QUAL: begin
        if (eoi && line_start_q) begin
          st      = fqp_pkg::ST_SHORT_QUAL;
          phase_q = fqp_pkg::PH_DELIM;
        end else if (eoi || b == fqp_pkg::CH_NL) begin
          if (qual_len_q == seq_len_q) done = 1'b1;
          else st = fqp_pkg::ST_MISMATCH;
          phase_q = fqp_pkg::PH_DELIM;
        end else begin
          cls          = fqp_pkg::CLS_QUAL;
          line_start_q = 1'b0;
          qual_len_q   = sat_inc(qual_len_q);
        end
      end
      fqp_pkg::PH_FSEQ: begin
        if (eoi) begin
          done    = 1'b1;
          phase_q = fqp_pkg::PH_DELIM;
        end else if (b == fqp_pkg::CH_NL) begin
          line_start_q = 1'b1;
        end else if (line_start_q && b == fqp_pkg::CH_GT) begin
          done    = 1'b1;
          phase_q = fqp_pkg::PH_HEADER;
        end else begin
          cls          = fqp_pkg::CLS_SEQ;
          line_start_q = 1'b0;
          seq_len_q    = sat_inc(seq_len_q);
        end
      end
      default: begin
        phase_q = fqp_pkg::PH_DELIM;
        if (eoi) begin
          st = fqp_pkg::ST_END;
        end else begin
          // first delimiter byte in auto mode fixes the format for good
          if (mode_q != fqp_pkg::MODE_FASTQ && mode_q != fqp_pkg::MODE_FASTA &&
              fmt_q == fqp_pkg::FMT_NONE) begin
            if (b == fqp_pkg::CH_AT) fmt_q = fqp_pkg::FMT_FASTQ;
            else if (b == fqp_pkg::CH_GT) fmt_q = fqp_pkg::FMT_FASTA;
            else fmt_q = fqp_pkg::FMT_UNKNOWN;
          end
          if ((effective_fmt() == fqp_pkg::FMT_FASTQ && b == fqp_pkg::CH_AT) ||
              (effective_fmt() == fqp_pkg::FMT_FASTA && b == fqp_pkg::CH_GT)) begin
            phase_q      = fqp_pkg::PH_HEADER;
            line_start_q = 1'b1;
            seq_len_q    = '0;
          end else begin
            st = fqp_pkg::ST_BAD_DELIM;
          end
        end
      end
    endcase
    r.sequence_length = 16'd0;
    if (done) begin
      st                = fqp_pkg::ST_DONE;
      rec_cnt_q         = rec_cnt_q + 32'd1;
      r.sequence_length = seq_len_q;
      // fasta record closed by the next '>' opens a new header right away
      if (phase_q == fqp_pkg::PH_HEADER) begin
        line_start_q = 1'b1;
        seq_len_q    = '0;
      end
    end
    r.out_byte     = b;
    r.byte_class   = cls;
    r.record_done  = done;
    r.status       = st;
    r.records_seen = rec_cnt_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    fqp_pkg::result_t want;
    if (!rst_ni) begin
      mode_q       = fqp_pkg::MODE_AUTO;
      fmt_q        = fqp_pkg::FMT_NONE;
      phase_q      = fqp_pkg::PH_DELIM;
      seq_len_q    = '0;
      qual_len_q   = '0;
      line_start_q = 1'b1;
      rec_cnt_q    = '0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results leave from the output register after their transaction is accepted, so check before predicting
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none actual 0x%0h",
                   $time, out_ch.out_byte);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
          check_field("byte_class", 32'(want.byte_class), 32'(out_ch.byte_class));
          check_field("record_done", 32'(want.record_done), 32'(out_ch.record_done));
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("sequence_length", 32'(want.sequence_length),
                      32'(out_ch.sequence_length));
          check_field("records_seen", want.records_seen, out_ch.records_seen);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data_byte, in_ch.end_of_input, want);
        expected_results.push_back(want);
      end
      // a register write takes effect for transactions after this edge
      if (psel && penable && pwrite && pready && paddr == FormatModeAddr) begin
        mode_q = pwdata[1:0];
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HoldCycles = 60;
  localparam logic [fqp_pkg::CfgAddrBits-1:0] FormatModeAddr =
    {fqp_pkg::REG_FORMAT_MODE, 2'b00};
  // unused register encoding, behaves as auto
  localparam logic [1:0] MODE_AUTO_ALT = 2'd3;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } file_item_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [fqp_pkg::CfgAddrBits-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req_cnt  = 0;
  int unsigned hold_served   = 0;
  int unsigned fail_count;
  int unsigned pending;

  file_item_t file_q[$];
  logic [1:0] auto_fmt;

  fqp_in_if  in_if ();
  fqp_out_if out_if ();

  always #10 clk_i = ~clk_i;

  fastq_fasta_record_parser i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  fqp_parse_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_req_cnt) begin
        hold_served++;
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic apb_write(input logic [fqp_pkg::CfgAddrBits-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] b, input logic eoi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_item(file_q[i].b, file_q[i].eoi);
    file_q.delete();
  endtask

  // wait until every transaction has come back, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [7:0] text_byte(input logic [7:0] avoid);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == fqp_pkg::CH_NL || v == avoid);
    return v;
  endfunction

  task automatic put(input logic [7:0] b, input logic eoi);
    file_q.push_back('{b: b, eoi: eoi});
  endtask

  task automatic put_end();
    put(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic add_record(input logic [1:0] fmt, input bit corrupt);
    file_item_t rec[$];
    int unsigned n;
    int unsigned q_len;
    int unsigned pos;
    if (fmt == fqp_pkg::FMT_FASTA) begin
      rec.push_back('{b: fqp_pkg::CH_GT, eoi: 1'b0});
      repeat ($urandom_range(6)) rec.push_back('{b: text_byte(fqp_pkg::CH_NL), eoi: 1'b0});
      rec.push_back('{b: fqp_pkg::CH_NL, eoi: 1'b0});
      repeat ($urandom_range(3)) begin
        repeat ($urandom_range(6)) rec.push_back('{b: text_byte(fqp_pkg::CH_GT), eoi: 1'b0});
        rec.push_back('{b: fqp_pkg::CH_NL, eoi: 1'b0});
      end
    end else begin
      n = $urandom_range(8);
      q_len = ($urandom_range(9) == 0) ? n + 1 : n;
      rec.push_back('{b: fqp_pkg::CH_AT, eoi: 1'b0});
      repeat ($urandom_range(6)) rec.push_back('{b: text_byte(fqp_pkg::CH_NL), eoi: 1'b0});
      rec.push_back('{b: fqp_pkg::CH_NL, eoi: 1'b0});
      repeat (n) rec.push_back('{b: text_byte(fqp_pkg::CH_NL), eoi: 1'b0});
      rec.push_back('{b: fqp_pkg::CH_NL, eoi: 1'b0});
      rec.push_back('{b: fqp_pkg::CH_PLUS, eoi: 1'b0});
      repeat ($urandom_range(3)) rec.push_back('{b: text_byte(fqp_pkg::CH_NL), eoi: 1'b0});
      rec.push_back('{b: fqp_pkg::CH_NL, eoi: 1'b0});
      repeat (q_len) rec.push_back('{b: text_byte(fqp_pkg::CH_NL), eoi: 1'b0});
      // quality line closed by end of input now and then
      if ($urandom_range(6) == 0) rec.push_back('{b: 8'($urandom_range(255)), eoi: 1'b1});
      else rec.push_back('{b: fqp_pkg::CH_NL, eoi: 1'b0});
    end
    if (corrupt) begin
      pos = $urandom_range(rec.size() - 1);
      if ($urandom_range(1) == 0) begin
        while (rec.size() > pos + 1) void'(rec.pop_back());
        rec.push_back('{b: 8'($urandom_range(255)), eoi: 1'b1});
      end else begin
        rec[pos].b = 8'($urandom_range(255));
      end
    end
    foreach (rec[i]) file_q.push_back(rec[i]);
  endtask

  task automatic build_random(input int unsigned n_items, input logic [1:0] fmt);
    int unsigned r;
    while (file_q.size() < n_items) begin
      r = $urandom_range(99);
      if (r < 3) put_end();
      else if (r < 8) put(8'($urandom_range(255)), 1'b0);
      else if (r < 15) add_record((fmt == fqp_pkg::FMT_FASTA) ? fqp_pkg::FMT_FASTQ :
                                                               fqp_pkg::FMT_FASTA, 1'b0);
      else add_record(fmt, r >= 80);
    end
    // leave the parser between records
    put_end();
  endtask

  initial begin
    logic [7:0] first;
    int unsigned pick;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= '0;
    in_if.end_of_input <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 75;

    // forced fastq: end between records, short header, missing plus, empty record
    apb_write(FormatModeAddr, 32'(fqp_pkg::MODE_FASTQ));
    put_end();
    put(fqp_pkg::CH_AT, 1'b0); put_end();
    put(fqp_pkg::CH_AT, 1'b0); put(8'hFF, 1'b0); put(fqp_pkg::CH_NL, 1'b0); put("A", 1'b0);
    put(fqp_pkg::CH_NL, 1'b0); put("x", 1'b0);
    put(fqp_pkg::CH_AT, 1'b0); put(fqp_pkg::CH_NL, 1'b0); put(fqp_pkg::CH_NL, 1'b0);
    put(fqp_pkg::CH_PLUS, 1'b0);
    put(fqp_pkg::CH_NL, 1'b0); put(fqp_pkg::CH_NL, 1'b0);
    send_file();
    drain();

    // forced fasta: record closed by '>', then short header at end of input
    apb_write(FormatModeAddr, 32'(fqp_pkg::MODE_FASTA));
    put(fqp_pkg::CH_GT, 1'b0); put(fqp_pkg::CH_NL, 1'b0); put("A", 1'b0);
    put(fqp_pkg::CH_NL, 1'b0);
    put(fqp_pkg::CH_GT, 1'b0); put_end();
    put(fqp_pkg::CH_GT, 1'b0); put(8'h00, 1'b0);
    send_file();
    drain();
    // mode flips inside the header: the record continues as fastq
    apb_write(FormatModeAddr, 32'(fqp_pkg::MODE_FASTQ));
    put(fqp_pkg::CH_NL, 1'b0); put("C", 1'b0); put(fqp_pkg::CH_NL, 1'b0);
    put(fqp_pkg::CH_PLUS, 1'b0);
    put(fqp_pkg::CH_NL, 1'b0); put("I", 1'b0); put_end();
    send_file();
    drain();

    // random fastq with a long receiver hold-off while the sender keeps offering bytes
    build_random(100, fqp_pkg::FMT_FASTQ);
    hold_req_cnt++;
    send_file();
    drain();
    apb_write(FormatModeAddr, 32'(fqp_pkg::MODE_FASTA));
    build_random(80, fqp_pkg::FMT_FASTA);
    send_file();
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 12;

    // auto mode: the first delimiter byte decides the format
    apb_write(FormatModeAddr, 32'(fqp_pkg::MODE_AUTO));
    pick = $urandom_range(9);
    if (pick < 6) begin
      auto_fmt = fqp_pkg::FMT_FASTQ;
    end else if (pick < 8) begin
      auto_fmt = fqp_pkg::FMT_FASTA;
    end else begin
      auto_fmt = fqp_pkg::FMT_UNKNOWN;
      do first = 8'($urandom_range(255));
      while (first == fqp_pkg::CH_AT || first == fqp_pkg::CH_GT);
      put(first, 1'b0);
    end
    build_random(100, (auto_fmt == fqp_pkg::FMT_FASTA) ? fqp_pkg::FMT_FASTA :
                                                          fqp_pkg::FMT_FASTQ);
    send_file();
    drain();
    apb_write(FormatModeAddr, 32'(MODE_AUTO_ALT));
    build_random(50, (auto_fmt == fqp_pkg::FMT_FASTA) ? fqp_pkg::FMT_FASTA :
                                                         fqp_pkg::FMT_FASTQ);
    hold_req_cnt++;
    send_file();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;

    // full rate on both sides
    apb_write(FormatModeAddr, 32'(fqp_pkg::MODE_FASTQ));
    build_random(50, fqp_pkg::FMT_FASTQ);
    send_file();
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
